[rtl/clpws_pkg.sv]
`timescale 1ns / 1ps

package clpws_pkg;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_GAP   = 4'd1,
    PH_PRE   = 4'd2,
    PH_RS    = 4'd3,
    PH_EH    = 4'd4,
    PH_EL    = 4'd5,
    PH_POWER = 4'd6,
    PH_IWAIT = 4'd7
  } phase_t;

  // Action codes carried in the input item
  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_SEND     = 2'd1,
    ACT_INIT     = 2'd2,
    ACT_SHUTDOWN = 2'd3
  } action_t;

  localparam int NumRegs     = 8;
  localparam int RegIdxW     = 3;
  localparam int AddrW       = 5;
  localparam int TickW       = 32;
  localparam int InitStepW   = 3;
  localparam int InDataW     = 8;
  localparam int InUserW     = 3;
  localparam int OutDataW    = 16;

  // Register indexes
  localparam logic [RegIdxW-1:0] REG_MIN_GAP     = 3'd0;
  localparam logic [RegIdxW-1:0] REG_PRE_DELAY   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_RS_SETUP    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_ENABLE_HIGH = 3'd3;
  localparam logic [RegIdxW-1:0] REG_ENABLE_LOW  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_INIT_GAP    = 3'd5;
  localparam logic [RegIdxW-1:0] REG_CLEAR_WAIT  = 3'd6;
  localparam logic [RegIdxW-1:0] REG_POWER_UP    = 3'd7;

  // Init step after which the long clear wait applies, the last command step and the final settle step
  localparam logic [InitStepW-1:0] STEP_CLEAR    = 3'd4;
  localparam logic [InitStepW-1:0] STEP_LAST_CMD = 3'd5;
  localparam logic [InitStepW-1:0] STEP_FINAL    = 3'd6;

  localparam logic [TickW-1:0] REG_RESET [NumRegs] = '{
    32'd0, 32'd16000, 32'd250, 32'd250, 32'd250, 32'd7500, 32'd500000, 32'd2500000
  };

  typedef struct packed {
    logic       accepted;
    logic       busy_res;
    logic [7:0] data_pins;
    logic       enable_pin;
    logic       rs_pin;
  } result_t;

  // Init command list: function set, function set, function set,
  // display on, clear, entry mode
  function automatic logic [7:0] init_cmd(input logic [InitStepW-1:0] step);
    logic [7:0] cmd;
    begin
      case (step)
        3'd0:    cmd = 8'h38;
        3'd1:    cmd = 8'h38;
        3'd2:    cmd = 8'h38;
        3'd3:    cmd = 8'h0C;
        3'd4:    cmd = 8'h01;
        3'd5:    cmd = 8'h06;
        default: cmd = 8'h38;
      endcase
      return cmd;
    end
  endfunction

endpackage

[rtl/char_lcd_parallel_write_sequencer_unit.sv]
`timescale 1ns / 1ps

// Eight-bit character-LCD write sequencer (RS, E, D7..D0). Each input item is
// one timer tick and yields exactly one result item giving the pin levels,
// busy flag and whether a send or init request in that item was taken. A
// send latches a byte while idle, waits for the minimum gap since the last
// byte, then plays pre-delay, RS setup, E high and E low hold. Init drives
// D high, waits the power-up time and writes 0x38 x3, 0x0C, 0x01, 0x06 with
// their gaps; shutdown drops all pins at once. Timing registers are written
// over APB at byte address 4*index; the minimum gap is compared live, the
// others take effect at the next countdown load. Rate: one item per clock;
// the whole tick is a single pass of next-state logic into the state
// registers, and one output register holds the result, so input and output
// stall together only when that register is full and not being taken.
module char_lcd_parallel_write_sequencer_unit (
  input  logic                             clk,
  input  logic                             rst,
  // input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [clpws_pkg::InDataW-1:0]    s_tdata,   // [7:0] data_byte
  input  logic [clpws_pkg::InUserW-1:0]    s_tuser,   // [1:0] action, [2] is_command
  // result items
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] rs_pin, [1] enable_pin, [9:2] data_pins, [10] busy_res, [11] accepted
  output logic [clpws_pkg::OutDataW-1:0]   m_tdata,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [clpws_pkg::AddrW-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  import clpws_pkg::*;

  // timing registers
  logic [TickW-1:0] cfg_reg [NumRegs];
  logic [RegIdxW-1:0] cfg_idx;

  // sequencer state
  phase_t               phase, phase_next;
  logic [TickW-1:0]     countdown, countdown_next;
  logic [TickW-1:0]     ticks_since_last, ticks_since_last_next;
  logic [7:0]           held_byte, held_byte_next;
  logic                 held_is_command, held_is_command_next;
  logic [InitStepW-1:0] init_step, init_step_next;
  logic                 in_init, in_init_next;
  logic                 rs_level, rs_level_next;
  logic                 enable_level, enable_level_next;
  logic [7:0]           data_level, data_level_next;
  logic                 acc_next;

  // result register
  result_t              res, res_next;

  logic                 s_accept;
  action_t              action;
  logic [7:0]           data_byte;
  logic                 is_command;
  logic [TickW-1:0]     tsl_inc;
  logic [InitStepW-1:0] step_inc;

  assign action     = action_t'(s_tuser[1:0]);
  assign is_command = s_tuser[2];
  assign data_byte  = s_tdata[7:0];

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  // ---------------- APB ----------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[AddrW-1:2];
  assign prdata  = cfg_reg[cfg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) cfg_reg[i] <= REG_RESET[i];
    end else if (psel && penable && pwrite && pready) begin
      cfg_reg[cfg_idx] <= pwdata;
    end
  end

  // ---------------- next state ----------------
  assign tsl_inc  = (ticks_since_last == '1) ? ticks_since_last
                                             : ticks_since_last + TickW'(1);
  assign step_inc = init_step + InitStepW'(1);

  always_comb begin
    phase_next            = phase;
    countdown_next        = countdown;
    ticks_since_last_next = tsl_inc;
    held_byte_next        = held_byte;
    held_is_command_next  = held_is_command;
    init_step_next        = init_step;
    in_init_next          = in_init;
    rs_level_next         = rs_level;
    enable_level_next     = enable_level;
    data_level_next       = data_level;
    acc_next              = 1'b0;

    if (action == ACT_SHUTDOWN) begin
      rs_level_next     = 1'b0;
      enable_level_next = 1'b0;
      data_level_next   = 8'h00;
      in_init_next      = 1'b0;
      init_step_next    = '0;
      phase_next        = PH_IDLE;
      countdown_next    = '0;
    end else if (action == ACT_SEND && phase == PH_IDLE) begin
      held_byte_next       = data_byte;
      held_is_command_next = is_command;
      phase_next           = PH_GAP;
      countdown_next       = '0;
      acc_next             = 1'b1;
    end else if (action == ACT_INIT && phase == PH_IDLE) begin
      data_level_next   = 8'hFF;
      rs_level_next     = 1'b0;
      enable_level_next = 1'b0;
      in_init_next      = 1'b1;
      init_step_next    = '0;
      phase_next        = PH_POWER;
      countdown_next    = cfg_reg[REG_POWER_UP];
      acc_next          = 1'b1;
    end else if (phase == PH_GAP) begin
      if (tsl_inc >= cfg_reg[REG_MIN_GAP]) begin
        phase_next     = PH_PRE;
        countdown_next = cfg_reg[REG_PRE_DELAY];
      end
    end else if (phase != PH_IDLE) begin
      if (countdown > TickW'(1)) begin
        countdown_next = countdown - TickW'(1);
      end else begin
        // last tick of a timed phase
        case (phase)
          PH_PRE: begin
            rs_level_next  = !held_is_command;
            phase_next     = PH_RS;
            countdown_next = cfg_reg[REG_RS_SETUP];
          end
          PH_RS: begin
            data_level_next   = held_byte;
            enable_level_next = 1'b1;
            phase_next        = PH_EH;
            countdown_next    = cfg_reg[REG_ENABLE_HIGH];
          end
          PH_EH: begin
            enable_level_next = 1'b0;
            phase_next        = PH_EL;
            countdown_next    = cfg_reg[REG_ENABLE_LOW];
          end
          PH_EL: begin
            if (in_init) begin
              phase_next     = PH_IWAIT;
              countdown_next = (init_step == STEP_CLEAR) ? cfg_reg[REG_CLEAR_WAIT]
                                                         : cfg_reg[REG_INIT_GAP];
            end else begin
              ticks_since_last_next = '0;
              phase_next            = PH_IDLE;
              countdown_next        = '0;
            end
          end
          PH_POWER: begin
            init_step_next       = '0;
            held_byte_next       = init_cmd('0);
            held_is_command_next = 1'b1;
            phase_next           = PH_PRE;
            countdown_next       = cfg_reg[REG_PRE_DELAY];
          end
          PH_IWAIT: begin
            init_step_next = step_inc;
            if (step_inc <= STEP_LAST_CMD) begin
              held_byte_next       = init_cmd(step_inc);
              held_is_command_next = 1'b1;
              phase_next           = PH_PRE;
              countdown_next       = cfg_reg[REG_PRE_DELAY];
            end else if (step_inc == STEP_FINAL) begin
              // trailing settle wait at the end of init
              phase_next     = PH_IWAIT;
              countdown_next = cfg_reg[REG_CLEAR_WAIT];
            end else begin
              init_step_next = '0;
              in_init_next   = 1'b0;
              phase_next     = PH_IDLE;
              countdown_next = '0;
            end
          end
          default: begin
            phase_next     = PH_IDLE;
            countdown_next = '0;
          end
        endcase
      end
    end
  end

  // ---------------- result ----------------
  always_comb begin
    res_next.rs_pin     = rs_level_next;
    res_next.enable_pin = enable_level_next;
    res_next.data_pins  = data_level_next;
    res_next.busy_res   = (phase_next != PH_IDLE);
    res_next.accepted   = acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      countdown        <= '0;
      ticks_since_last <= '1;
      held_byte        <= '0;
      held_is_command  <= 1'b0;
      init_step        <= '0;
      in_init          <= 1'b0;
      rs_level         <= 1'b0;
      enable_level     <= 1'b0;
      data_level       <= 8'hFF;
    end else if (s_accept) begin
      phase            <= phase_next;
      countdown        <= countdown_next;
      ticks_since_last <= ticks_since_last_next;
      held_byte        <= held_byte_next;
      held_is_command  <= held_is_command_next;
      init_step        <= init_step_next;
      in_init          <= in_init_next;
      rs_level         <= rs_level_next;
      enable_level     <= enable_level_next;
      data_level       <= data_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      res <= res_next;
    end
  end

  assign m_tdata = {{(OutDataW - $bits(result_t)){1'b0}}, res};

endmodule

[dv/char_lcd_parallel_write_sequencer_unit_tb.sv]
`timescale 1ns / 1ps

module char_lcd_parallel_write_sequencer_unit_tb;
  import clpws_pkg::*;

  localparam int StallLimit = 2000;   // cycles with no handshake and no APB select
  localparam int EndCycles  = 10;     // settle time once everything has arrived

  // Init command bytes in order: function set x3, display on, clear, entry mode
  localparam logic [7:0] INIT_BYTES [6] = '{8'h38, 8'h38, 8'h38, 8'h0C, 8'h01, 8'h06};

  typedef struct {
    action_t    act;
    logic [7:0] data_byte;
    logic       is_cmd;
  } lcd_req_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;   // [7:0] data_byte
  logic [InUserW-1:0]  s_tuser = '0;   // [1:0] action, [2] is_command
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // [0] rs_pin, [1] enable_pin, [9:2] data_pins, [10] busy_res, [11] accepted
  logic [OutDataW-1:0] m_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  char_lcd_parallel_write_sequencer_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the sequencer: timing registers and bus state
  // ---------------------------------------------------------------------------
  logic [31:0] timing [NumRegs];
  phase_t      seq_phase;
  logic [31:0] count_left;
  logic [31:0] since_last;     // ticks since the last sent byte ended, saturating
  logic [7:0]  latched_byte;
  logic        latched_cmd;
  logic [2:0]  step_no;
  logic        initialising;
  logic        rs_q;
  logic        en_q;
  logic [7:0]  d_q;

  lcd_req_t    pending_q [$];  // items waiting for the driver
  result_t     pin_states_q [$];  // expected result items, oldest first

  int          presented_cnt = 0;
  int          taken_cnt = 0;
  int          idle_cycles = 0;
  int          errors = 0;
  bit          quiet = 1'b0;   // no idling on either side when set

  task automatic load(input phase_t ph, input logic [31:0] w);
    seq_phase  = ph;
    count_left = w;
  endtask

  task automatic load_init_cmd();
    latched_byte = INIT_BYTES[step_no];
    latched_cmd  = 1'b1;
    load(PH_PRE, timing[REG_PRE_DELAY]);
  endtask

  // Last tick of a timed phase: move the bus on and load the next wait
  task automatic finish_phase();
    case (seq_phase)
      PH_PRE: begin
        rs_q = ~latched_cmd;
        load(PH_RS, timing[REG_RS_SETUP]);
      end
      PH_RS: begin
        d_q  = latched_byte;
        en_q = 1'b1;
        load(PH_EH, timing[REG_ENABLE_HIGH]);
      end
      PH_EH: begin
        en_q = 1'b0;
        load(PH_EL, timing[REG_ENABLE_LOW]);
      end
      PH_EL: begin
        if (initialising) begin
          load(PH_IWAIT, (step_no == STEP_CLEAR) ? timing[REG_CLEAR_WAIT]
                                                 : timing[REG_INIT_GAP]);
        end else begin
          since_last = '0;
          load(PH_IDLE, '0);
        end
      end
      PH_POWER: begin
        step_no = '0;
        load_init_cmd();
      end
      PH_IWAIT: begin
        step_no++;
        if (step_no <= STEP_LAST_CMD) begin
          load_init_cmd();
        end else if (step_no == STEP_FINAL) begin
          load(PH_IWAIT, timing[REG_CLEAR_WAIT]);
        end else begin
          step_no      = '0;
          initialising = 1'b0;
          load(PH_IDLE, '0);
        end
      end
      default: load(PH_IDLE, '0);
    endcase
  endtask

  // One timer tick: update the shadow and queue the pin levels it should give
  task automatic lcd_tick(input action_t act, input logic [7:0] data_byte,
                          input logic is_cmd);
    result_t r;
    logic    took;
    took = 1'b0;
    if (since_last != '1) since_last++;
    if (act == ACT_SHUTDOWN) begin
      rs_q         = 1'b0;
      en_q         = 1'b0;
      d_q          = '0;
      initialising = 1'b0;
      step_no      = '0;
      load(PH_IDLE, '0);
    end else if (act == ACT_SEND && seq_phase == PH_IDLE) begin
      latched_byte = data_byte;
      latched_cmd  = is_cmd;
      load(PH_GAP, '0);
      took = 1'b1;
    end else if (act == ACT_INIT && seq_phase == PH_IDLE) begin
      d_q          = '1;
      rs_q         = 1'b0;
      en_q         = 1'b0;
      initialising = 1'b1;
      step_no      = '0;
      load(PH_POWER, timing[REG_POWER_UP]);
      took = 1'b1;
    end else if (seq_phase == PH_GAP) begin
      // gap test always against the live min_gap value
      if (since_last >= timing[REG_MIN_GAP]) load(PH_PRE, timing[REG_PRE_DELAY]);
    end else if (seq_phase != PH_IDLE) begin
      if (count_left > 1) count_left--;
      else finish_phase();
    end
    r.rs_pin     = rs_q;
    r.enable_pin = en_q;
    r.data_pins  = d_q;
    r.busy_res   = (seq_phase != PH_IDLE);
    r.accepted   = took;
    pin_states_q.push_back(r);
  endtask

  task automatic check_field(input string what, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: both sides sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        lcd_tick(action_t'(s_tuser[1:0]), s_tdata, s_tuser[2]);
        taken_cnt <= taken_cnt + 1;
      end
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[11:0]);
        if (pin_states_q.size() == 0) begin
          $display("%0t: result item with nothing expected, expected none, got %0h",
                   $time, m_tdata);
          errors++;
        end else begin
          want = pin_states_q.pop_front();
          check_field("rs_pin", 8'(want.rs_pin), 8'(got.rs_pin));
          check_field("enable_pin", 8'(want.enable_pin), 8'(got.enable_pin));
          check_field("data_pins", want.data_pins, got.data_pins);
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          check_field("accepted", 8'(want.accepted), 8'(got.accepted));
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: presents items at the falling edge, holds each until taken
  // ---------------------------------------------------------------------------
  int send_gap = 0;
  always @(negedge clk) begin
    lcd_req_t cur;
    logic     nv;
    if (!s_tvalid || taken_cnt == presented_cnt) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (!quiet && pending_q.size() > 0 && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 17) - 1;
      end else if (!rst && pending_q.size() > 0) begin
        cur = pending_q.pop_front();
        s_tdata <= cur.data_byte;
        s_tuser <= {cur.is_cmd, cur.act};
        presented_cnt++;
        nv = 1'b1;
      end
      s_tvalid <= nv;
    end
  end

  // Result side back-pressure in random bursts
  int stall_left = 0;
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      rdy = 1'b0;
    end
    m_tready <= rdy;
  end

  // Watchdog: ends the run if nothing moves for too long
  initial begin
    do @(posedge clk); while (idle_cycles < StallLimit);
    $display("%0t: no handshake for %0d cycles", $time, StallLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_item(input action_t act, input logic [7:0] data_byte,
                           input logic is_cmd);
    lcd_req_t it;
    it.act       = act;
    it.data_byte = data_byte;
    it.is_cmd    = is_cmd;
    pending_q.push_back(it);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_item(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Mostly ticks with sends and inits mixed in; shutdown_pct sets how often a
  // running byte or init gets cut short
  task automatic push_random(input int n, input int shutdown_pct);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < shutdown_pct)
        push_item(ACT_SHUTDOWN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (r < shutdown_pct + 6)
        push_item(ACT_INIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (r < shutdown_pct + 28)
        push_item(ACT_SEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else
        push_ticks(1);
    end
  endtask

  // Wait until every item is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_q.size() != 0 || taken_cnt != presented_cnt ||
           pin_states_q.size() != 0);
  endtask

  // APB write, then read back; shadow copy updated at the same point
  task automatic reg_write(input int idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= AddrW'(4 * idx);
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    timing[idx[RegIdxW-1:0]] = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== val) begin
      $display("%0t: readback of register %0d, expected %0h, got %0h",
               $time, idx, val, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] vals [NumRegs]);
    for (int i = 0; i < NumRegs; i++) reg_write(i, vals[i]);
  endtask

  initial begin
    logic [31:0] vals [NumRegs];
    int          n_items;
    int          sd_pct;

    for (int i = 0; i < NumRegs; i++) timing[i] = REG_RESET[i];
    seq_phase    = PH_IDLE;
    count_left   = '0;
    since_last   = '1;
    latched_byte = '0;
    latched_cmd  = 1'b0;
    step_no      = '0;
    initialising = 1'b0;
    rs_q         = 1'b0;
    en_q         = 1'b0;
    d_q          = '1;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset timings: a byte is taken and then stuck in its pre-delay, so
    // busy refusals and shutdown abandoning a byte and an init come first
    push_item(ACT_SEND, 8'hA5, 1'b0);
    push_item(ACT_SEND, 8'h5A, 1'b1);      // refused, busy
    push_item(ACT_INIT, 8'h00, 1'b0);      // refused, busy
    push_ticks(1);
    push_item(ACT_SHUTDOWN, 8'hFF, 1'b1);
    push_item(ACT_INIT, 8'hFF, 1'b1);
    push_ticks(1);
    push_item(ACT_SHUTDOWN, 8'h00, 1'b0);
    wait_drained();

    // All waits at zero: every phase lasts one tick
    for (int i = 0; i < NumRegs; i++) vals[i] = '0;
    write_all(vals);
    push_item(ACT_SEND, 8'hFF, 1'b1);      // command, RS low
    push_ticks(5);
    push_item(ACT_SEND, 8'h00, 1'b0);      // display data, RS high
    push_ticks(5);
    push_item(ACT_INIT, 8'h3C, 1'b0);
    push_ticks(3);
    push_item(ACT_SEND, 8'h81, 1'b0);      // refused during init
    push_item(ACT_SHUTDOWN, 8'h7E, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      n_items = 200;
      sd_pct  = 1;
      case (ph)
        0: begin
          // short waits, no shutdown, so init runs to its end
          for (int i = 0; i < NumRegs; i++) vals[i] = $urandom_range(0, 3);
          sd_pct = 0;
        end
        1: begin
          for (int i = 0; i < NumRegs; i++) vals[i] = $urandom_range(0, 6);
          vals[REG_MIN_GAP] = $urandom_range(0, 20);
        end
        2: begin
          // largest gap: after one byte ends the next never leaves its gap
          for (int i = 0; i < NumRegs; i++) vals[i] = $urandom_range(0, 2);
          vals[REG_MIN_GAP] = '1;
          n_items = 120;
        end
        3: begin
          // every wait at its top value; only shutdown frees the block
          for (int i = 0; i < NumRegs; i++) vals[i] = '1;
          n_items = 60;
          sd_pct  = 4;
        end
        4: begin
          for (int i = 0; i < NumRegs; i++)
            vals[i] = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 5);
          sd_pct = 2;
        end
        5: begin
          for (int i = 0; i < NumRegs; i++) vals[i] = $urandom_range(0, 4);
          vals[REG_MIN_GAP] = $urandom_range(0, 40);
        end
        default: begin
          // final stretch at full rate on both sides
          for (int i = 0; i < NumRegs; i++) vals[i] = $urandom_range(0, 3);
          quiet   = 1'b1;
          n_items = 260;
        end
      endcase
      write_all(vals);
      push_random(n_items, sd_pct);
      wait_drained();
    end

    repeat (EndCycles) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/clpws_pkg.sv
rtl/char_lcd_parallel_write_sequencer_unit.sv
dv/char_lcd_parallel_write_sequencer_unit_tb.sv
